[sv/tga_rle_pixel_decoder_unit_macros.svh]
// Assertion macros for the TGA RLE decoder modules; tgarle_back uses them.
// Each use expects clk and rst_n in scope.
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TGARLE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgarle: same-cycle check failed");
// Next-cycle implication.
`define TGARLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgarle: next-cycle check failed");
`else
`define TGARLE_ASSERT_IMPL(label, ante, cons)
`define TGARLE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/tgarle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tgarle_pkg;

    // Packet header split: below RUN_BASE is raw, else run of (header - RUN_BIAS)
    localparam logic [7:0] RUN_BASE = 8'd128;
    localparam logic [7:0] RUN_BIAS = 8'd127;

    // Configuration register indexes
    localparam logic [1:0] CFG_BPP    = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // One classified stream byte, front to back
    typedef struct packed {
        logic        start;
        logic        is_pixel;
        logic [31:0] gather;
        logic [7:0]  count;
        logic [9:0]  span;       // count * depth
        logic [8:0]  span_less;  // (count - 1) * depth
    } token_t;

    // One run result
    typedef struct packed {
        logic [31:0] pixel;
        logic [7:0]  count;
        logic [33:0] offset;
        logic        done;
        logic        clamped;
    } result_t;

    // Token queue status
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Pixel depth in bytes: zero acts as one, above four acts as four
    function automatic logic [2:0] depth_of(input logic [2:0] bpp);
        logic [2:0] d;
        d = bpp;
        if (bpp == 3'd0) d = 3'd1;
        else if (bpp > 3'd4) d = 3'd4;
        return d;
    endfunction

endpackage

`default_nettype wire

[sv/tga_rle_pixel_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                 Payload
// input     in         push / full               stream_byte, start_image
// result    out        empty / pop               run_pixel, run_count, start_offset,
//                                                image_done, run_clamped
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One byte transfers per cycle while full is low; the token of a pixel's last byte is
// registered in the token queue, then its result in the result queue, before it shows.
// The token queue between parser and offset stage and the result queue hold two entries
// each, so queue back-up only raises full when both fill behind a stalled pop.
// A config transfer holds full high while the image size product (width * height,
// then times depth) settles through its two register stages, prod_reg then size_reg.
// Reset clears all packet, offset and queue state; config returns to 4 / 1 / 1.

module tga_rle_pixel_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  stream_byte,
    input  wire logic        start_image,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      run_pixel,
    output logic [7:0]       run_count,
    output logic [33:0]      start_offset,
    output logic             image_done,
    output logic             run_clamped,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [2:0]  bpp_reg;
    logic [15:0] width_reg, height_reg;
    logic [31:0] prod_reg;
    logic [33:0] size_reg;
    logic [1:0]  settle_reg;
    logic [2:0]  depth;
    logic        in_accept, cfg_write;

    tgarle_pkg::token_t  front_tok, head_tok;
    tgarle_pkg::qstat_t  qstat;
    tgarle_pkg::result_t res;
    logic                tok_pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign depth     = tgarle_pkg::depth_of(bpp_reg);
    // hold input off while the size pipeline catches up with a config transfer
    assign full      = qstat.full || (settle_reg != 2'd0);
    assign in_accept = push && !full;

    // Config registers and the registered image size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg    <= 3'd4;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            prod_reg   <= 32'd1;
            size_reg   <= 34'd4;
            settle_reg <= 2'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    tgarle_pkg::CFG_BPP:    bpp_reg    <= cfg_data[2:0];
                    tgarle_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    tgarle_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    default: ;  // unused index: drop the write
                endcase
                settle_reg <= 2'd2;
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
            prod_reg <= {16'd0, width_reg} * {16'd0, height_reg};
            size_reg <= {2'b00, prod_reg} * {31'd0, depth};
        end
    end

    // Front: parse headers and gather pixel bytes
    tgarle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .depth    (depth),
        .accept   (in_accept),
        .in_byte  (stream_byte),
        .in_start (start_image),
        .tok      (front_tok)
    );

    // Short queue decoupling the parser from the offset stage
    tgarle_token_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (front_tok),
        .pop       (tok_pop),
        .head      (head_tok),
        .stat      (qstat)
    );

    // Back: advance offset, clamp at image end, drop bytes after the end
    tgarle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .size      (size_reg),
        .depth     (depth),
        .tok       (head_tok),
        .tok_valid (!qstat.empty),
        .tok_pop   (tok_pop),
        .pop       (pop),
        .out_empty (empty),
        .res       (res)
    );

    assign run_pixel    = res.pixel;
    assign run_count    = res.count;
    assign start_offset = res.offset;
    assign image_done   = res.done;
    assign run_clamped  = res.clamped;

endmodule

`default_nettype wire

[sv/tgarle_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tgarle_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [2:0]          depth,
    input  wire logic                accept,
    input  wire logic [7:0]          in_byte,
    input  wire logic                in_start,
    output tgarle_pkg::token_t       tok
);

    logic        expect_reg, expect_next;
    logic        run_reg, run_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  bip_reg, bip_next;
    logic [31:0] gather_reg, gather_next;

    logic        e_expect, e_run;
    logic [7:0]  e_left;
    logic [1:0]  e_bip;
    logic [31:0] e_gather, gather_or;
    logic [7:0]  count;
    logic [9:0]  span;

    always_comb
    begin
        // a start marker clears packet state before the byte is parsed
        e_expect = in_start ? 1'b1  : expect_reg;
        e_run    = in_start ? 1'b0  : run_reg;
        e_left   = in_start ? 8'd0  : left_reg;
        e_bip    = in_start ? 2'd0  : bip_reg;
        e_gather = in_start ? 32'd0 : gather_reg;

        gather_or = e_gather | ({24'd0, in_byte} << {e_bip, 3'b000});
        count     = e_run ? e_left : 8'd1;
        span      = {2'd0, count} * {7'd0, depth};

        expect_next = e_expect;
        run_next    = e_run;
        left_next   = e_left;
        bip_next    = e_bip;
        gather_next = e_gather;

        tok.start     = in_start;
        tok.is_pixel  = 1'b0;
        tok.gather    = gather_or;
        tok.count     = count;
        tok.span      = span;
        tok.span_less = 9'(span - {7'd0, depth});

        if (e_expect)
        begin
            expect_next = 1'b0;
            bip_next    = 2'd0;
            gather_next = 32'd0;
            if (in_byte < tgarle_pkg::RUN_BASE)
            begin
                run_next  = 1'b0;
                left_next = in_byte + 8'd1;
            end
            else
            begin
                run_next  = 1'b1;
                left_next = in_byte - tgarle_pkg::RUN_BIAS;
            end
        end
        else if (({1'b0, e_bip} + 3'd1) < depth)
        begin
            bip_next    = e_bip + 2'd1;
            gather_next = gather_or;
        end
        else
        begin
            // last byte of a pixel: hand it to the back end
            tok.is_pixel = 1'b1;
            bip_next     = 2'd0;
            gather_next  = 32'd0;
            left_next    = e_run ? 8'd0 : e_left - 8'd1;
            expect_next  = (left_next == 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg <= 1'b1;
            run_reg    <= 1'b0;
            left_reg   <= 8'd0;
            bip_reg    <= 2'd0;
            gather_reg <= 32'd0;
        end
        else if (accept)
        begin
            expect_reg <= expect_next;
            run_reg    <= run_next;
            left_reg   <= left_next;
            bip_reg    <= bip_next;
            gather_reg <= gather_next;
        end
    end

endmodule

`default_nettype wire

[sv/tgarle_token_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tgarle_token_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire tgarle_pkg::token_t  push_data,
    input  wire logic                pop,
    output tgarle_pkg::token_t       head,
    output tgarle_pkg::qstat_t       stat
);

    tgarle_pkg::token_t mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + 2'd1;
        else if (do_pop && !do_push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wr_reg <= !wr_reg;
            if (do_pop) rd_reg <= !rd_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[sv/tgarle_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "tga_rle_pixel_decoder_unit_macros.svh"

module tgarle_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [33:0]         size,
    input  wire logic [2:0]          depth,
    input  wire tgarle_pkg::token_t  tok,
    input  wire logic                tok_valid,
    output logic                     tok_pop,
    input  wire logic                pop,
    output logic                     out_empty,
    output tgarle_pkg::result_t      res
);

    localparam logic [17:0] DIV3_MUL = 18'd171;  // ceil(2^9 / 3)

    logic [34:0] off_reg, off_next;
    logic        fin_reg, fin_next;

    logic [34:0] eff_off;
    logic        eff_fin;
    logic [35:0] diff;
    logic [34:0] remain;
    logic        past, clamped, done, emit;
    logic [9:0]  r_ext, room;
    logic [17:0] div3_prod;

    tgarle_pkg::result_t res_in;
    tgarle_pkg::result_t out_mem_reg [2];
    logic       out_wr_reg, out_rd_reg;
    logic [1:0] out_cnt_reg, out_cnt_next;
    logic       out_full, out_pop;

    assign out_full  = (out_cnt_reg == 2'd2);
    assign out_empty = (out_cnt_reg == 2'd0);
    assign out_pop   = pop && !out_empty;
    assign tok_pop   = tok_valid && !out_full;
    assign res       = out_mem_reg[out_rd_reg];

    always_comb
    begin
        eff_off = tok.start ? 35'd0 : off_reg;
        eff_fin = tok.start ? 1'b0 : fin_reg;
        diff    = {2'b00, size} - {1'b0, eff_off};
        remain  = diff[34:0];
        past    = diff[35] || (diff == 36'd0);

        // clamp when the last pixel of the run starts at or past the end
        clamped = (remain[34:9] == 26'd0) && (tok.span_less >= remain[8:0]);
        done    = (remain[34:10] == 25'd0) && (tok.span >= remain[9:0]);

        // pixels left = ceil(remain / depth); only read when clamped
        r_ext     = {1'b0, remain[8:0]};
        div3_prod = {8'd0, r_ext + 10'd2} * DIV3_MUL;
        case (depth)
            3'd2:    room = (r_ext + 10'd1) >> 1;
            3'd3:    room = {1'b0, div3_prod[17:9]};
            3'd4:    room = (r_ext + 10'd3) >> 2;
            default: room = r_ext;
        endcase

        emit = tok_pop && !eff_fin && !past && tok.is_pixel;

        res_in.pixel   = tok.gather;
        res_in.count   = clamped ? room[7:0] : tok.count;
        res_in.offset  = eff_off[33:0];
        res_in.done    = done;
        res_in.clamped = clamped;

        off_next = eff_off;
        fin_next = eff_fin;
        if (!eff_fin)
        begin
            if (past) fin_next = 1'b1;
            else if (tok.is_pixel)
            begin
                off_next = eff_off + {25'd0, tok.span};
                if (done) fin_next = 1'b1;
            end
        end

        out_cnt_next = out_cnt_reg;
        if (emit && !out_pop) out_cnt_next = out_cnt_reg + 2'd1;
        else if (out_pop && !emit) out_cnt_next = out_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (emit) out_mem_reg[out_wr_reg] <= res_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg     <= 35'd0;
            fin_reg     <= 1'b0;
            out_wr_reg  <= 1'b0;
            out_rd_reg  <= 1'b0;
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            if (tok_pop)
            begin
                off_reg <= off_next;
                fin_reg <= fin_next;
            end
            if (emit) out_wr_reg <= !out_wr_reg;
            if (out_pop) out_rd_reg <= !out_rd_reg;
            out_cnt_reg <= out_cnt_next;
        end
    end

    `TGARLE_ASSERT_IMPL(a_clamp_implies_done, emit && clamped, done)
    `TGARLE_ASSERT_NEXT(a_done_sets_fin, emit && done, fin_reg)
    `TGARLE_ASSERT_NEXT(a_offset_step, emit, off_reg == $past(eff_off) + {25'd0, $past(tok.span)})

endmodule

`default_nettype wire
